>>> hdl/bbg_pkg.sv
// Shared constants, codes and types of the bicubic block gradient unit.
package bbg_pkg;

  // Store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int ROW_W    = 7;
  localparam int COL_W    = 7;
  localparam int SAMPLE_W = 15;
  localparam int GRAD_W   = 16;
  localparam int TAP_W    = 16;
  localparam int SIZE_W   = 8;
  localparam int SHIFT_W  = 4;
  localparam int LIMIT_W  = 15;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(8);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  // Position arithmetic: holds the largest extent plus two
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int POS_W   = ($clog2(MAX_DIM + 3) > SIZE_W) ? $clog2(MAX_DIM + 3) : SIZE_W;

  // Neighbour fetch: eight samples as four address pairs
  localparam int NBR     = 8;
  localparam int NBR_W   = $clog2(NBR);
  localparam int PAIRS   = NBR / 2;
  localparam int PHASE_W = $clog2(PAIRS);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PAIRS - 1);

  // Datapath widths
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = TAP_W + DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = SUM_W;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_WIDTH    = 3'd0,
    REG_BLOCK_HEIGHT   = 3'd1,
    REG_INNER_TAP_NEAR = 3'd2,
    REG_INNER_TAP_FAR  = 3'd3,
    REG_EDGE_TAP_NEAR  = 3'd4,
    REG_EDGE_TAP_FAR   = 3'd5,
    REG_ROUND_SHIFT    = 3'd6,
    REG_CLAMP_LIMIT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        [SIZE_W-1:0]  block_width;
    logic        [SIZE_W-1:0]  block_height;
    logic signed [TAP_W-1:0]   inner_tap_near;
    logic signed [TAP_W-1:0]   inner_tap_far;
    logic signed [TAP_W-1:0]   edge_tap_near;
    logic signed [TAP_W-1:0]   edge_tap_far;
    logic        [SHIFT_W-1:0] round_shift;
    logic        [LIMIT_W-1:0] clamp_limit;
  } cfg_t;

  // Classified item. Writes use addr[0]; reads use pairs (next, prev):
  // x near, x far, y near, y far.
  typedef struct packed {
    op_t                          op;
    logic                         store_ok;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         edge_x;
    logic                         edge_y;
    logic [NBR-1:0][ADDR_W-1:0]   addr;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

>>> hdl/bbg_if.sv
// Handshake channels of the gradient unit: items in, results out, configuration writes.
interface bbg_cmd_if;
  import bbg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic        [ROW_W-1:0]    row;
  logic        [COL_W-1:0]    col;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, op, row, col, sample, input ready);
  modport sink   (input valid, op, row, col, sample, output ready);
endinterface

interface bbg_grad_if;
  import bbg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] x_gradient;
  logic signed [GRAD_W-1:0] y_gradient;
  modport source (output valid, x_gradient, y_gradient, input ready);
  modport sink   (input valid, x_gradient, y_gradient, output ready);
endinterface

interface bbg_cfg_if;
  import bbg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bbg_ram.sv
// Simple dual-read RAM: one write port, two registered read ports.
module bbg_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/bbg_front.sv
// Front end: accepts items, clamps the location, works out neighbour addresses, queues them.
module bbg_front (
  input  logic               clk,
  input  logic               rst,
  input  bbg_pkg::cfg_t      regs,
  bbg_cmd_if.sink            cmd,
  output bbg_pkg::cmd_slot_t head,
  input  logic               head_pop
);
  import bbg_pkg::*;

  localparam int QPTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0] prev2;
    logic [POS_W-1:0] prev1;
    logic [POS_W-1:0] next1;
    logic [POS_W-1:0] next2;
    logic             at_edge;
  } nbr_t;

  // Extent in use, saturated to [1, lim]
  function automatic logic [POS_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                input logic [POS_W-1:0] lim);
    logic [POS_W-1:0] ve;
    ve = POS_W'(v);
    if (ve == '0) return POS_W'(1);
    if (ve > lim) return lim;
    return ve;
  endfunction

  // Neighbour indices clamped to [0, last]
  function automatic nbr_t neighbours(input logic [POS_W-1:0] p,
                                      input logic [POS_W-1:0] last);
    nbr_t n;
    n.prev1   = (p > POS_W'(0)) ? p - POS_W'(1) : '0;
    n.prev2   = (p > POS_W'(1)) ? p - POS_W'(2) : '0;
    n.next1   = (p + POS_W'(1) <= last) ? p + POS_W'(1) : last;
    n.next2   = (p + POS_W'(2) <= last) ? p + POS_W'(2) : last;
    n.at_edge = (p == '0) || (p == last);
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c));
  endfunction

  logic [POS_W-1:0] bw, bh, last_c, last_r, row_e, col_e, prow, pcol;
  nbr_t             nx, ny;
  cmd_t             new_cmd;

  cmd_t              q_mem [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  // Classification of the incoming item
  always_comb begin
    bw     = sat_size(regs.block_width, POS_W'(MAX_WIDTH));
    bh     = sat_size(regs.block_height, POS_W'(MAX_HEIGHT));
    last_c = bw - POS_W'(1);
    last_r = bh - POS_W'(1);
    row_e  = POS_W'(cmd.row);
    col_e  = POS_W'(cmd.col);
    prow   = (row_e > last_r) ? last_r : row_e;
    pcol   = (col_e > last_c) ? last_c : col_e;
    nx     = neighbours(pcol, last_c);
    ny     = neighbours(prow, last_r);

    new_cmd.op       = op_t'(cmd.op);
    new_cmd.store_ok = (row_e < POS_W'(MAX_HEIGHT)) && (col_e < POS_W'(MAX_WIDTH));
    new_cmd.sample   = cmd.sample;
    new_cmd.edge_x   = nx.at_edge;
    new_cmd.edge_y   = ny.at_edge;
    new_cmd.addr[0]  = store_addr(prow, nx.next1);
    new_cmd.addr[1]  = store_addr(prow, nx.prev1);
    new_cmd.addr[2]  = store_addr(prow, nx.next2);
    new_cmd.addr[3]  = store_addr(prow, nx.prev2);
    new_cmd.addr[4]  = store_addr(ny.next1, pcol);
    new_cmd.addr[5]  = store_addr(ny.prev1, pcol);
    new_cmd.addr[6]  = store_addr(ny.next2, pcol);
    new_cmd.addr[7]  = store_addr(ny.prev2, pcol);
    // a write goes to the raw location, not the clamped one
    if (new_cmd.op == OP_WRITE) begin
      new_cmd.addr[0] = store_addr(row_e, col_e);
    end
  end

  assign cmd.ready  = (count != QCNT_W'(CMDQ_DEPTH));
  assign push       = cmd.valid && cmd.ready;
  assign head.valid = (count != '0);
  assign head.cmd   = q_mem[rd_ptr];

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (head_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({push, head_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> count != '0)
    else $error("front queue popped while empty");
`endif

endmodule

>>> hdl/bbg_back.sv
// Back end: sample store, neighbour fetch, tap multiply, rounding, clamping and result queue.
module bbg_back (
  input  logic               clk,
  input  logic               rst,
  input  bbg_pkg::cfg_t      regs,
  input  bbg_pkg::cmd_slot_t head,
  output logic               head_pop,
  bbg_grad_if.source         grad
);
  import bbg_pkg::*;

  localparam int OQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
  } grad_pair_t;

  // Fetch control
  logic [PHASE_W-1:0] phase;
  logic               is_read, do_write, credit_ok, issue, start, pop_out;
  logic               ram_we, at_edge;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  logic signed [SAMPLE_W-1:0] rd_a, rd_b;
  logic signed [TAP_W-1:0]    coef;
  logic [OQ_CNT_W-1:0]        claims;

  // Pipeline
  logic                      s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic [PHASE_W-1:0]        s1_phase, s2_phase, s3_phase;
  logic signed [TAP_W-1:0]   s1_coef, s2_coef;
  logic signed [DIFF_W-1:0]  s2_diff;
  logic signed [PROD_W-1:0]  s3_prod, acc;
  logic signed [SUM_W-1:0]   s4_t;
  logic                      s4_axis_y, s5_axis_y, s6_axis_y, s5_neg;
  logic [MAG_W-1:0]          s5_mag, bias, shifted;
  logic signed [SUM_W:0]     t_ext, bias_ext, mag_s;
  logic [LIMIT_W-1:0]        sat;
  logic [GRAD_W-1:0]         mag16;
  logic signed [GRAD_W-1:0]  res, s6_res, x_hold;

  // Result queue
  grad_pair_t          oq_mem [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr, oq_rd;
  logic [OQ_CNT_W-1:0] oq_count;
  logic                push;

  // Issue: a write is a single store access, a read four address pairs
  always_comb begin
    is_read   = head.valid && (head.cmd.op == OP_READ);
    do_write  = head.valid && (head.cmd.op == OP_WRITE);
    credit_ok = claims < OQ_CNT_W'(OUTQ_DEPTH);
    issue     = is_read && ((phase != '0) || credit_ok);
    start     = issue && (phase == '0);
    head_pop  = do_write || (issue && (phase == LAST_PHASE));
    ram_we    = do_write && head.cmd.store_ok;
    raddr_a   = head.cmd.addr[NBR_W'({phase, 1'b0})];
    raddr_b   = head.cmd.addr[NBR_W'({phase, 1'b1})];
    at_edge   = phase[1] ? head.cmd.edge_y : head.cmd.edge_x;
    if (at_edge) begin
      coef = phase[0] ? regs.edge_tap_far : regs.edge_tap_near;
    end else begin
      coef = phase[0] ? regs.inner_tap_far : regs.inner_tap_near;
    end
  end

  bbg_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (head.cmd.addr[0]),
    .wdata   (head.cmd.sample),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Phase counter and result credits
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      claims <= '0;
    end else begin
      if (issue) begin
        phase <= phase + PHASE_W'(1);
      end
      unique case ({start, pop_out})
        2'b10:   claims <= claims + OQ_CNT_W'(1);
        2'b01:   claims <= claims - OQ_CNT_W'(1);
        default: claims <= claims;
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid && s3_phase[0];
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // Rounding and saturation terms
  always_comb begin
    bias     = (MAG_W'(1) << regs.round_shift) >> 1;
    t_ext    = {s4_t[SUM_W-1], s4_t};
    bias_ext = {1'b0, bias};
    mag_s    = s4_t[SUM_W-1] ? bias_ext - t_ext : t_ext + bias_ext;
    shifted  = s5_mag >> regs.round_shift;
    sat      = (shifted > MAG_W'(regs.clamp_limit)) ? regs.clamp_limit
                                                    : shifted[LIMIT_W-1:0];
    mag16    = {1'b0, sat};
    res      = s5_neg ? GRAD_W'(0) - mag16 : mag16;
  end

  // Datapath: difference, product, pair sum, magnitude, shift and clamp
  always_ff @(posedge clk) begin
    s1_phase  <= phase;
    s1_coef   <= coef;
    s2_phase  <= s1_phase;
    s2_coef   <= s1_coef;
    s2_diff   <= DIFF_W'(rd_a) - DIFF_W'(rd_b);
    s3_phase  <= s2_phase;
    s3_prod   <= PROD_W'(s2_coef) * PROD_W'(s2_diff);
    if (s3_valid && !s3_phase[0]) begin
      acc <= s3_prod;
    end
    s4_t      <= SUM_W'(acc) + SUM_W'(s3_prod);
    s4_axis_y <= s3_phase[1];
    s5_neg    <= s4_t[SUM_W-1];
    s5_mag    <= mag_s[MAG_W-1:0];
    s5_axis_y <= s4_axis_y;
    s6_res    <= res;
    s6_axis_y <= s5_axis_y;
    if (s6_valid && !s6_axis_y) begin
      x_hold <= s6_res;
    end
  end

  // Result queue
  assign push            = s6_valid && s6_axis_y;
  assign pop_out         = grad.valid && grad.ready;
  assign grad.valid      = (oq_count != '0);
  assign grad.x_gradient = oq_mem[oq_rd].x;
  assign grad.y_gradient = oq_mem[oq_rd].y;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (push) begin
        oq_wr <= (oq_wr == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wr + OQ_PTR_W'(1);
      end
      if (pop_out) begin
        oq_rd <= (oq_rd == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rd + OQ_PTR_W'(1);
      end
      unique case ({push, pop_out})
        2'b10:   oq_count <= oq_count + OQ_CNT_W'(1);
        2'b01:   oq_count <= oq_count - OQ_CNT_W'(1);
        default: oq_count <= oq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_mem[oq_wr] <= '{x: x_hold, y: s6_res};
    end
  end

`ifndef ASSERT_OFF
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> oq_count < OQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue overflow");

  a_claims_bound: assert property (@(posedge clk) disable iff (rst)
    claims <= OQ_CNT_W'(OUTQ_DEPTH))
    else $error("more results claimed than queue entries");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    oq_count <= claims)
    else $error("queued results exceed claimed credits");

  a_read_pop_last: assert property (@(posedge clk) disable iff (rst)
    head_pop && is_read |-> phase == LAST_PHASE)
    else $error("read item left the queue before its last fetch");

  a_x_before_y: assert property (@(posedge clk) disable iff (rst)
    push |-> $past(s6_valid, 2) && !$past(s6_axis_y, 2))
    else $error("vertical gradient without horizontal partner");
`endif

endmodule

>>> hdl/bicubic_block_gradient.sv
// Top level of the bicubic block gradient unit: configuration registers, front and back ends.
//
//  channel | dir | payload                        | accepted when
//  cmd     | in  | op, row, col, sample           | cmd.valid && cmd.ready
//  grad    | out | x_gradient, y_gradient         | grad.valid && grad.ready
//  cfg     | in  | index, data                    | cfg.valid && cfg.ready (always ready)
//
// A write item is a single store access in the back end; a read item is four fetches,
// set by the two read ports of the sample store fetching eight neighbours in pairs.
// Synchronous active-high reset clears control state only; the sample store has
// no clearing pass and an entry reads as undefined until written.
// A two-item queue sits in front of the back end; up to four results are held
// at the output, and reads wait while four results are owed.
module bicubic_block_gradient (
  input  logic clk,
  input  logic rst,
  bbg_cmd_if.sink   cmd,
  bbg_grad_if.source grad,
  bbg_cfg_if.sink   cfg
);
  import bbg_pkg::*;

  cfg_t      regs;
  cmd_slot_t head;
  logic      head_pop;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.block_width    <= SIZE_RESET;
      regs.block_height   <= SIZE_RESET;
      regs.inner_tap_near <= '0;
      regs.inner_tap_far  <= '0;
      regs.edge_tap_near  <= '0;
      regs.edge_tap_far   <= '0;
      regs.round_shift    <= '0;
      regs.clamp_limit    <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_BLOCK_WIDTH:    regs.block_width    <= cfg.data[SIZE_W-1:0];
        REG_BLOCK_HEIGHT:   regs.block_height   <= cfg.data[SIZE_W-1:0];
        REG_INNER_TAP_NEAR: regs.inner_tap_near <= cfg.data[TAP_W-1:0];
        REG_INNER_TAP_FAR:  regs.inner_tap_far  <= cfg.data[TAP_W-1:0];
        REG_EDGE_TAP_NEAR:  regs.edge_tap_near  <= cfg.data[TAP_W-1:0];
        REG_EDGE_TAP_FAR:   regs.edge_tap_far   <= cfg.data[TAP_W-1:0];
        REG_ROUND_SHIFT:    regs.round_shift    <= cfg.data[SHIFT_W-1:0];
        REG_CLAMP_LIMIT:    regs.clamp_limit    <= cfg.data[LIMIT_W-1:0];
        default:            regs                <= regs;
      endcase
    end
  end

  bbg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .cmd      (cmd),
    .head     (head),
    .head_pop (head_pop)
  );

  bbg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .head     (head),
    .head_pop (head_pop),
    .grad     (grad)
  );

endmodule

>>> sim/bicubic_block_gradient_test.sv
// Self-checking testbench of the bicubic block gradient unit: stores samples, checks both gradients.
`timescale 1ns / 1ps

module bicubic_block_gradient_test;
  import bbg_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
  } grad_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbg_cmd_if  cmd_if();
  bbg_grad_if grad_if();
  bbg_cfg_if  cfg_if();

  bicubic_block_gradient uut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_if),
    .grad (grad_if),
    .cfg  (cfg_if)
  );

  // Predictor state: sample store, which entries hold a sample, live settings
  logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
  bit                         sample_known [STORE_DEPTH];
  cfg_t                       cfg_now;
  grad_pair_t                 owed_grads [$];
  grad_pair_t                 want;

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  stall_cycles = 0;
  int  hold_req    = 0;
  int  hold_left   = 0;
  bit  steady      = 1'b0;

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Block extent in use: saturated to [1, top]
  function automatic int size_in_use(logic [SIZE_W-1:0] v, int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic longint sample_at(int r, int c);
    return longint'(sample_mem[r * MAX_WIDTH + c]);
  endfunction

  // Gradient along one axis, rounded as sign and magnitude, then saturated
  function automatic logic signed [GRAD_W-1:0] axis_gradient(int r, int c, int bw, int bh,
                                                            bit vert);
    int     n, p, ip, ip2, in1, in2;
    bit     at_edge;
    longint cn, cf, d1, d2, acc, bias, res, lim;
    n   = vert ? bh : bw;
    p   = vert ? r : c;
    ip  = (p > 0) ? p - 1 : 0;
    ip2 = (p > 1) ? p - 2 : 0;
    in1 = (p + 1 < n) ? p + 1 : n - 1;
    in2 = (p + 2 < n) ? p + 2 : n - 1;
    at_edge = (p == 0) || (p == n - 1);
    if (at_edge) begin
      cn = longint'($signed(cfg_now.edge_tap_near));
      cf = longint'($signed(cfg_now.edge_tap_far));
    end else begin
      cn = longint'($signed(cfg_now.inner_tap_near));
      cf = longint'($signed(cfg_now.inner_tap_far));
    end
    if (vert) begin
      d1 = sample_at(in1, c) - sample_at(ip, c);
      d2 = sample_at(in2, c) - sample_at(ip2, c);
    end else begin
      d1 = sample_at(r, in1) - sample_at(r, ip);
      d2 = sample_at(r, in2) - sample_at(r, ip2);
    end
    acc  = cn * d1 + cf * d2;
    bias = (longint'(1) << cfg_now.round_shift) >>> 1;
    if (acc < 0) res = -((-acc + bias) >>> cfg_now.round_shift);
    else res = (acc + bias) >>> cfg_now.round_shift;
    lim = longint'(cfg_now.clamp_limit);
    if (res < -lim) res = -lim;
    if (res > lim) res = lim;
    return res[GRAD_W-1:0];
  endfunction

  // Both gradients of a read; location saturated into the block in use
  function automatic grad_pair_t predict_gradients(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
    int bw, bh, r, c;
    grad_pair_t g;
    bw = size_in_use(cfg_now.block_width, MAX_WIDTH);
    bh = size_in_use(cfg_now.block_height, MAX_HEIGHT);
    r  = (int'(row) > bh - 1) ? bh - 1 : int'(row);
    c  = (int'(col) > bw - 1) ? bw - 1 : int'(col);
    g.x = axis_gradient(r, c, bw, bh, 1'b0);
    g.y = axis_gradient(r, c, bw, bh, 1'b1);
    return g;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 15'sh3fff;
      1:       return 15'sh4000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [TAP_W-1:0] rand_tap();
    case ($urandom_range(5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small blocks; now and then the largest and out-of-range sizes
  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(9))
      0:       return SIZE_W'($urandom_range(7));
      1:       return SIZE_W'(MAX_WIDTH);
      2:       return SIZE_W'($urandom_range(255, 129));
      3:       return SIZE_W'($urandom_range(127, 17));
      default: return SIZE_W'($urandom_range(16, 8));
    endcase
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t s;
    s.block_width    = rand_size();
    s.block_height   = rand_size();
    s.inner_tap_near = rand_tap();
    s.inner_tap_far  = rand_tap();
    s.edge_tap_near  = rand_tap();
    s.edge_tap_far   = rand_tap();
    s.round_shift    = SHIFT_W'($urandom);
    case ($urandom_range(4))
      0:       s.clamp_limit = LIMIT_RESET;
      1:       s.clamp_limit = '0;
      2:       s.clamp_limit = LIMIT_W'($urandom_range(300));
      default: s.clamp_limit = LIMIT_W'($urandom);
    endcase
    return s;
  endfunction

  // Wait until every owed result is back, then let the back end settle
  task automatic quiesce();
    cmd_if.valid <= 1'b0;
    while (owed_grads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_BLOCK_WIDTH:    cfg_now.block_width    = value[SIZE_W-1:0];
      REG_BLOCK_HEIGHT:   cfg_now.block_height   = value[SIZE_W-1:0];
      REG_INNER_TAP_NEAR: cfg_now.inner_tap_near = value;
      REG_INNER_TAP_FAR:  cfg_now.inner_tap_far  = value;
      REG_EDGE_TAP_NEAR:  cfg_now.edge_tap_near  = value;
      REG_EDGE_TAP_FAR:   cfg_now.edge_tap_far   = value;
      REG_ROUND_SHIFT:    cfg_now.round_shift    = value[SHIFT_W-1:0];
      REG_CLAMP_LIMIT:    cfg_now.clamp_limit    = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // All eight registers, unused upper data bits random
  task automatic load_settings(cfg_t s);
    quiesce();
    write_reg(REG_BLOCK_WIDTH,    {8'($urandom), s.block_width});
    write_reg(REG_BLOCK_HEIGHT,   {8'($urandom), s.block_height});
    write_reg(REG_INNER_TAP_NEAR, s.inner_tap_near);
    write_reg(REG_INNER_TAP_FAR,  s.inner_tap_far);
    write_reg(REG_EDGE_TAP_NEAR,  s.edge_tap_near);
    write_reg(REG_EDGE_TAP_FAR,   s.edge_tap_far);
    write_reg(REG_ROUND_SHIFT,    {12'($urandom), s.round_shift});
    write_reg(REG_CLAMP_LIMIT,    {1'($urandom), s.clamp_limit});
    cfg_if.valid <= 1'b0;
  endtask

  // One item on the command channel; predictor updated at acceptance
  task automatic send_item(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic signed [SAMPLE_W-1:0] smp);
    int addr;
    while (!steady && $urandom_range(99) < 30) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.op     <= op;
    cmd_if.row    <= row;
    cmd_if.col    <= col;
    cmd_if.sample <= smp;
    do @(posedge clk); while (!cmd_if.ready);
    addr = int'(row) * MAX_WIDTH + int'(col);
    if (op == OP_WRITE) begin
      sample_mem[addr]   = smp;
      sample_known[addr] = 1'b1;
    end else begin
      owed_grads.push_back(predict_gradients(row, col));
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Read a gradient; any neighbour not yet stored is written first
  task automatic read_at(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int bw, bh, r, c, rr, cc;
    bw = size_in_use(cfg_now.block_width, MAX_WIDTH);
    bh = size_in_use(cfg_now.block_height, MAX_HEIGHT);
    r  = (int'(row) > bh - 1) ? bh - 1 : int'(row);
    c  = (int'(col) > bw - 1) ? bw - 1 : int'(col);
    for (int k = -2; k <= 2; k++) begin
      cc = c + k;
      if (cc < 0) cc = 0;
      if (cc > bw - 1) cc = bw - 1;
      if (!sample_known[r * MAX_WIDTH + cc])
        send_item(OP_WRITE, ROW_W'(r), COL_W'(cc), rand_sample());
      rr = r + k;
      if (rr < 0) rr = 0;
      if (rr > bh - 1) rr = bh - 1;
      if (!sample_known[rr * MAX_WIDTH + c])
        send_item(OP_WRITE, ROW_W'(rr), COL_W'(c), rand_sample());
    end
    send_item(OP_READ, row, col, rand_sample());
  endtask

  // Write or read, mostly inside the block in use
  task automatic random_item();
    int bw, bh;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    bw = size_in_use(cfg_now.block_width, MAX_WIDTH);
    bh = size_in_use(cfg_now.block_height, MAX_HEIGHT);
    if ($urandom_range(9) < 8) begin
      r = ROW_W'($urandom_range(bh - 1));
      c = COL_W'($urandom_range(bw - 1));
    end else begin
      r = ROW_W'($urandom);
      c = COL_W'($urandom);
    end
    if ($urandom_range(99) < 45) send_item(OP_WRITE, r, c, rand_sample());
    else read_at(r, c);
  endtask

  // Extreme samples and taps, edge and interior, reads outside the block
  task automatic test_field_extremes();
    cfg_t s;
    s = cfg_now;
    s.inner_tap_near = 16'h7fff;
    s.inner_tap_far  = 16'h8000;
    s.edge_tap_near  = 16'h8000;
    s.edge_tap_far   = 16'h7fff;
    load_settings(s);
    send_item(OP_WRITE, 7'd0, 7'd0, 15'sh3fff);
    send_item(OP_WRITE, 7'd0, 7'd1, 15'sh4000);
    send_item(OP_WRITE, 7'd1, 7'd0, 15'sh4000);
    send_item(OP_WRITE, 7'd127, 7'd127, 15'sh3fff);
    read_at(7'd0, 7'd0);
    read_at(7'd1, 7'd1);
    read_at(7'd7, 7'd7);
    read_at(7'd127, 7'd127);
    read_at(7'd127, 7'd0);
    read_at(7'd0, 7'd127);
    read_at(7'd3, 7'd4);
    // widest shift, then saturation to zero and to a small bound
    s.round_shift = 4'hf;
    load_settings(s);
    read_at(7'd3, 7'd4);
    s.round_shift = 4'd1;
    s.clamp_limit = '0;
    load_settings(s);
    read_at(7'd0, 7'd1);
    s.round_shift = 4'd2;
    s.clamp_limit = 15'd5;
    load_settings(s);
    read_at(7'd1, 7'd1);
  endtask

  // Single-sample block, zero and oversized extents, the full store
  task automatic test_block_sizes();
    logic [SIZE_W-1:0] widths  [6] = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd8, 8'd2};
    logic [SIZE_W-1:0] heights [6] = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd128, 8'd3};
    cfg_t s;
    for (int i = 0; i < 6; i++) begin
      s = rand_settings();
      s.block_width  = widths[i];
      s.block_height = heights[i];
      load_settings(s);
      read_at(7'd127, 7'd127);
      read_at(7'd0, 7'd0);
      repeat (10) random_item();
    end
  endtask

  // Results held off for a long stretch while items keep coming
  task automatic test_output_stall();
    load_settings(rand_settings());
    hold_req = HOLD_CYCLES;
    repeat (30) random_item();
  endtask

  // Sender stops until every result has come back, then resumes
  task automatic test_drain_pause();
    repeat (20) random_item();
    quiesce();
    repeat (20) random_item();
  endtask

  // Random settings per stretch; the second stretch runs with no idling
  task automatic test_random_traffic();
    int phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      load_settings(rand_settings());
      steady = (phase == 1);
      repeat (PHASE_ITEMS) if (items_sent < ITEM_TARGET) random_item();
      phase++;
    end
    steady = 1'b0;
  endtask

  // Result side: ready idles at random, or holds off for a counted stretch
  always @(negedge clk) begin
    if (hold_left > 0) begin
      grad_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      grad_if.ready <= 1'b0;
    end else begin
      grad_if.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Compare each result with the oldest owed one
  always @(posedge clk) begin
    if (!rst && grad_if.valid && grad_if.ready) begin
      if (owed_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: x=%0d y=%0d", grad_if.x_gradient, grad_if.y_gradient);
      end else begin
        want = owed_grads.pop_front();
        if (grad_if.x_gradient !== want.x || grad_if.y_gradient !== want.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("gradient mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.x, want.y, grad_if.x_gradient, grad_if.y_gradient);
        end
      end
    end
  end

  // Watchdog: too long with no item accepted on any channel
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (grad_if.valid && grad_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("bicubic_block_gradient verification failed");
        $finish;
      end
    end
  end

  initial begin
    cmd_if.valid  = 1'b0;
    cmd_if.op     = OP_WRITE;
    cmd_if.row    = '0;
    cmd_if.col    = '0;
    cmd_if.sample = '0;
    grad_if.ready = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_BLOCK_WIDTH;
    cfg_if.data   = '0;
    cfg_now.block_width    = SIZE_RESET;
    cfg_now.block_height   = SIZE_RESET;
    cfg_now.inner_tap_near = '0;
    cfg_now.inner_tap_far  = '0;
    cfg_now.edge_tap_near  = '0;
    cfg_now.edge_tap_far   = '0;
    cfg_now.round_shift    = '0;
    cfg_now.clamp_limit    = LIMIT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_field_extremes();
    test_block_sizes();
    test_output_stall();
    test_drain_pause();
    test_random_traffic();

    quiesce();
    if (mismatches == 0) begin
      $display("bicubic_block_gradient verification clean");
    end else begin
      $display("bicubic_block_gradient verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bbg_pkg.sv
hdl/bbg_if.sv
hdl/bbg_ram.sv
hdl/bbg_front.sv
hdl/bbg_back.sv
hdl/bicubic_block_gradient.sv
sim/bicubic_block_gradient_test.sv
